@@ src/ibct_pkg.sv @@
// Shared types and constants for the IO block cache table.
// No dependencies; every other file of the block refers to this package.
package ibct_pkg;

  // Field widths of the request and result transfers
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned FILE_W  = 16;
  localparam int unsigned BLOCK_W = 32;
  localparam int unsigned RC_W    = 3;
  localparam int unsigned SLOT_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC    = 3'd0,
    REQ_COMPLETE = 3'd1,
    REQ_FIND     = 3'd2,
    REQ_RELEASE  = 3'd3,
    REQ_INVAL    = 3'd4
  } req_e;

  typedef enum logic [RC_W-1:0] {
    RC_OK         = 3'd0,
    RC_NOT_FOUND  = 3'd1,
    RC_NOT_READY  = 3'd2,
    RC_ALL_LOCKED = 3'd3,
    RC_REF_ERROR  = 3'd4
  } rc_e;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_INVALID  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_MATCH = 2'd1,
    S_EXEC  = 2'd2
  } state_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic match;    // register the slot compare vectors
    logic exec;     // update the table and load the result register
  } cmd_t;

endpackage

@@ src/ibct_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on ibct_pkg for the field widths.
interface ibct_req_if;
  logic                          valid;
  logic                          ready;
  logic [ibct_pkg::REQ_W-1:0]    req_type;
  logic [ibct_pkg::FILE_W-1:0]   file_id;
  logic [ibct_pkg::BLOCK_W-1:0]  block_idx;

  modport source (output valid, req_type, file_id, block_idx, input ready);
  modport sink   (input valid, req_type, file_id, block_idx, output ready);
endinterface

interface ibct_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ibct_pkg::RC_W-1:0]   result_code;
  logic [ibct_pkg::SLOT_W-1:0] slot;
  logic                        duplicate_key;
  logic                        in_use_hit;

  modport source (output valid, result_code, slot, duplicate_key, in_use_hit, input ready);
  modport sink   (input valid, result_code, slot, duplicate_key, in_use_hit, output ready);
endinterface

@@ src/io_block_cache_table.sv @@
// IO block cache table: slot table keyed by file id and block number.
// Flow: after the request transfer the match phase registers the compare vectors, then
// the update phase loads the result register. A new request is accepted in the update
// phase of the last one; a waiting result stalls only the update phase.
// Reset: all slots invalid with file id 0 and no references, ring pointer 0.
// Depends on ibct_pkg, ibct_if, ibct_ctrl and ibct_dp.
module io_block_cache_table #(
  parameter int unsigned NUM_SLOTS = 32,
  parameter int unsigned REF_BITS  = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ibct_req_if.sink     req_i,
  ibct_rsp_if.source   rsp_o
);

  ibct_pkg::cmd_t cmd;

  // Sequencer
  ibct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .rsp_ready_i (rsp_o.ready),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  // Slot table datapath
  ibct_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .REF_BITS  (REF_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .req_type_i      (req_i.req_type),
    .file_id_i       (req_i.file_id),
    .block_idx_i     (req_i.block_idx),
    .result_code_o   (rsp_o.result_code),
    .slot_o          (rsp_o.slot),
    .duplicate_key_o (rsp_o.duplicate_key),
    .in_use_hit_o    (rsp_o.in_use_hit)
  );

endmodule

@@ src/ibct_ctrl.sv @@
// Request sequencer: idle, match and execute phases plus the result valid flag.
// Depends on ibct_pkg for the state and command types.
module ibct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              rsp_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output ibct_pkg::cmd_t    cmd_o
);

  ibct_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // Result register can take a new result this cycle
  assign out_free = !out_valid_q || rsp_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ibct_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ibct_pkg::S_MATCH;
      end
      ibct_pkg::S_MATCH: begin
        state_d = ibct_pkg::S_EXEC;
      end
      ibct_pkg::S_EXEC: begin
        if (out_free) state_d = in_valid_i ? ibct_pkg::S_MATCH : ibct_pkg::S_IDLE;
      end
      default: state_d = ibct_pkg::S_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.match   = 1'b0;
    cmd_o.exec    = 1'b0;
    unique case (state_q)
      ibct_pkg::S_IDLE:  in_ready_o = 1'b1;
      ibct_pkg::S_MATCH: cmd_o.match = 1'b1;
      ibct_pkg::S_EXEC: begin
        in_ready_o = out_free;
        cmd_o.exec = out_free;
      end
      default: in_ready_o = 1'b0;
    endcase
    cmd_o.capture = in_valid_i && in_ready_o;
  end

  // Hold the result valid until its transfer completes
  always_comb begin
    if (cmd_o.exec) out_valid_d = 1'b1;
    else if (rsp_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ibct_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/ibct_dp.sv @@
// Slot table datapath: key store, status and counts, compare vectors,
// ring allocation select and the result register. Depends on ibct_pkg.
module ibct_dp #(
  parameter int unsigned NUM_SLOTS = 32,
  parameter int unsigned REF_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ibct_pkg::cmd_t                cmd_i,
  input  logic [ibct_pkg::REQ_W-1:0]    req_type_i,
  input  logic [ibct_pkg::FILE_W-1:0]   file_id_i,
  input  logic [ibct_pkg::BLOCK_W-1:0]  block_idx_i,
  output logic [ibct_pkg::RC_W-1:0]     result_code_o,
  output logic [ibct_pkg::SLOT_W-1:0]   slot_o,
  output logic                          duplicate_key_o,
  output logic                          in_use_hit_o
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned EXT_W = (IDX_W > ibct_pkg::SLOT_W) ? IDX_W : ibct_pkg::SLOT_W;
  localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(NUM_SLOTS - 1);
  localparam logic [REF_BITS-1:0] REF_MAX  = {REF_BITS{1'b1}};

  // Slot table
  logic [ibct_pkg::FILE_W-1:0]  slot_file_q  [NUM_SLOTS];
  logic [ibct_pkg::BLOCK_W-1:0] slot_block_q [NUM_SLOTS];
  ibct_pkg::status_e            slot_status_q[NUM_SLOTS];
  logic [REF_BITS-1:0]          slot_refs_q  [NUM_SLOTS];
  logic [IDX_W-1:0]             oldest_q, oldest_d;

  // Latched request
  logic [ibct_pkg::REQ_W-1:0]   req_q;
  logic [ibct_pkg::FILE_W-1:0]  fid_q;
  logic [ibct_pkg::BLOCK_W-1:0] blk_q;

  // Registered compare vectors
  logic [NUM_SLOTS-1:0] key_hit_q, file_hit_q, free_q, busy_q;

  // Result register
  logic [ibct_pkg::RC_W-1:0]   rc_q, rc_d;
  logic [ibct_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic                        dup_q, dup_d;
  logic                        inuse_q, inuse_d;

  // Table update controls
  logic                  alloc_we, stat_we, ref_we, inval_we;
  logic [IDX_W-1:0]      upd_idx;
  ibct_pkg::status_e     stat_val;
  logic [REF_BITS-1:0]   ref_val;

  logic [IDX_W-1:0]      hit_idx, free_lo_idx, free_hi_idx, alloc_idx;
  logic [NUM_SLOTS-1:0]  free_hi;
  logic [EXT_W-1:0]      slot_ext;
  logic                  fid_ok;

  // Latch the accepted request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      fid_q <= file_id_i;
      blk_q <= block_idx_i;
    end
  end

  // Compare every slot against the request key
  always_ff @(posedge clk_i) begin
    if (cmd_i.match) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        file_hit_q[i] <= (slot_file_q[i] == fid_q);
        key_hit_q[i]  <= (slot_file_q[i] == fid_q) && (slot_block_q[i] == blk_q);
        free_q[i]     <= (slot_status_q[i] != ibct_pkg::ST_PENDING) &&
                         (slot_refs_q[i] == '0);
        busy_q[i]     <= (slot_refs_q[i] != '0);
      end
    end
  end

  // Lowest matching slot and ring-ordered free slot
  always_comb begin
    hit_idx     = '0;
    free_lo_idx = '0;
    free_hi_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      free_hi[i] = free_q[i] && (IDX_W'(i) >= oldest_q);
      if (key_hit_q[i]) hit_idx = IDX_W'(i);
      if (free_q[i]) free_lo_idx = IDX_W'(i);
      if (free_hi[i]) free_hi_idx = IDX_W'(i);
    end
    alloc_idx = (|free_hi) ? free_hi_idx : free_lo_idx;
  end

  // Decide the result and the table update
  always_comb begin
    fid_ok   = (fid_q != '0);
    rc_d     = ibct_pkg::RC_NOT_FOUND;
    slot_ext = '0;
    dup_d    = 1'b0;
    inuse_d  = 1'b0;
    alloc_we = 1'b0;
    stat_we  = 1'b0;
    ref_we   = 1'b0;
    inval_we = 1'b0;
    upd_idx  = hit_idx;
    stat_val = ibct_pkg::ST_COMPLETE;
    ref_val  = slot_refs_q[hit_idx];
    oldest_d = oldest_q;
    if (fid_ok) begin
      unique case (req_q)
        ibct_pkg::REQ_ALLOC: begin
          dup_d = |key_hit_q;
          if (|free_q) begin
            alloc_we = 1'b1;
            upd_idx  = alloc_idx;
            rc_d     = ibct_pkg::RC_OK;
            slot_ext = EXT_W'(alloc_idx);
            oldest_d = (alloc_idx == LAST_IDX) ? '0 : alloc_idx + 1'b1;
          end else begin
            rc_d = ibct_pkg::RC_ALL_LOCKED;
          end
        end
        ibct_pkg::REQ_COMPLETE: begin
          if (|key_hit_q) begin
            stat_we  = 1'b1;
            rc_d     = ibct_pkg::RC_OK;
            slot_ext = EXT_W'(hit_idx);
          end
        end
        ibct_pkg::REQ_FIND: begin
          if (|key_hit_q) begin
            slot_ext = EXT_W'(hit_idx);
            if (slot_status_q[hit_idx] != ibct_pkg::ST_COMPLETE) begin
              rc_d = ibct_pkg::RC_NOT_READY;
            end else if (slot_refs_q[hit_idx] == REF_MAX) begin
              rc_d = ibct_pkg::RC_REF_ERROR;
            end else begin
              ref_we  = 1'b1;
              ref_val = slot_refs_q[hit_idx] + 1'b1;
              rc_d    = ibct_pkg::RC_OK;
            end
          end
        end
        ibct_pkg::REQ_RELEASE: begin
          if (|key_hit_q) begin
            slot_ext = EXT_W'(hit_idx);
            if (slot_refs_q[hit_idx] == '0) begin
              rc_d = ibct_pkg::RC_REF_ERROR;
            end else begin
              ref_we  = 1'b1;
              ref_val = slot_refs_q[hit_idx] - 1'b1;
              rc_d    = ibct_pkg::RC_OK;
            end
          end
        end
        ibct_pkg::REQ_INVAL: begin
          inval_we = 1'b1;
          inuse_d  = |(file_hit_q & busy_q);
          if (|file_hit_q) rc_d = ibct_pkg::RC_OK;
        end
        default: rc_d = ibct_pkg::RC_NOT_FOUND;
      endcase
    end
    slot_d = slot_ext[ibct_pkg::SLOT_W-1:0];
  end

  // Update status, counts and the ring pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_file_q[i]   <= '0;
        slot_status_q[i] <= ibct_pkg::ST_INVALID;
        slot_refs_q[i]   <= '0;
      end
    end else if (cmd_i.exec) begin
      oldest_q <= oldest_d;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (alloc_we && upd_idx == IDX_W'(i)) begin
          slot_file_q[i]   <= fid_q;
          slot_status_q[i] <= ibct_pkg::ST_PENDING;
        end
        if (stat_we && upd_idx == IDX_W'(i)) slot_status_q[i] <= stat_val;
        if (ref_we && upd_idx == IDX_W'(i)) slot_refs_q[i] <= ref_val;
        if (inval_we && file_hit_q[i]) slot_status_q[i] <= ibct_pkg::ST_INVALID;
      end
    end
  end

  // Block numbers only matter once a slot holds a file id
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && alloc_we) slot_block_q[upd_idx] <= blk_q;
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rc_q    <= rc_d;
      slot_q  <= slot_d;
      dup_q   <= dup_d;
      inuse_q <= inuse_d;
    end
  end

  assign result_code_o   = rc_q;
  assign slot_o          = slot_q;
  assign duplicate_key_o = dup_q;
  assign in_use_hit_o    = inuse_q;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for io_block_cache_table: directed table, then random requests.
// Depends on ibct_pkg, ibct_if and the block RTL; checks use a table model or typed row values.
module tb;
  import ibct_pkg::*;

  localparam int unsigned NUM_SLOTS = 32;
  localparam int unsigned REF_BITS  = 8;
  localparam int unsigned REF_MAX   = (1 << REF_BITS) - 1;
  localparam int unsigned N_RANDOM  = 800;
  localparam int unsigned HOLD_LEN  = 80;

  // Request codes the block does not define
  localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_C = 3'd7;

  typedef struct packed {
    rc_e               rc;
    logic [SLOT_W-1:0] slot;
    logic              dup;
    logic              inuse;
  } table_rsp_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [FILE_W-1:0]  fid;
    logic [BLOCK_W-1:0] blk;
    logic               typed;
    table_rsp_t         want;
  } dir_row_t;

  typedef struct packed {
    logic [FILE_W-1:0]  fid;
    logic [BLOCK_W-1:0] blk;
  } key_t;

  logic clk_i;
  logic rst_ni;

  ibct_req_if req_if ();
  ibct_rsp_if rsp_if ();

  io_block_cache_table #(
    .NUM_SLOTS(NUM_SLOTS),
    .REF_BITS (REF_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Model of the slot table
  logic [FILE_W-1:0]  tbl_file   [NUM_SLOTS];
  logic [BLOCK_W-1:0] tbl_block  [NUM_SLOTS];
  status_e            tbl_status [NUM_SLOTS];
  int unsigned        tbl_refs   [NUM_SLOTS];
  int unsigned        ring_ptr;

  table_rsp_t pending_rsp_q[$];
  dir_row_t   dir_rows[$];
  key_t       live_keys[$];

  int unsigned n_errors;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned rcv_cycle;
  int unsigned stall_cnt;
  int unsigned hold_cnt;
  bit          hold_rsp_req;
  bit          steady_tail;

  // Apply one request to the table model and return the response it gives
  function automatic table_rsp_t table_update(input logic [REQ_W-1:0]   req,
                                              input logic [FILE_W-1:0]  fid,
                                              input logic [BLOCK_W-1:0] blk);
    table_rsp_t  r;
    int          hit;
    int unsigned s;
    r.rc    = RC_NOT_FOUND;
    r.slot  = '0;
    r.dup   = 1'b0;
    r.inuse = 1'b0;
    hit     = -1;
    // lowest matching slot wins
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (tbl_file[i] == fid && tbl_block[i] == blk) hit = i;
    end
    if (fid != '0) begin
      case (req)
        REQ_ALLOC: begin
          r.dup = (hit >= 0);
          r.rc  = RC_ALL_LOCKED;
          // walk the ring, skipping pending and referenced slots
          for (int n = 0; n < NUM_SLOTS && r.rc != RC_OK; n++) begin
            s        = ring_ptr;
            ring_ptr = (s + 1) % NUM_SLOTS;
            if (tbl_status[s] != ST_PENDING && tbl_refs[s] == 0) begin
              tbl_file[s]   = fid;
              tbl_block[s]  = blk;
              tbl_status[s] = ST_PENDING;
              r.rc          = RC_OK;
              r.slot        = SLOT_W'(s);
            end
          end
        end
        REQ_COMPLETE: begin
          if (hit >= 0) begin
            tbl_status[hit] = ST_COMPLETE;
            r.rc            = RC_OK;
            r.slot          = SLOT_W'(hit);
          end
        end
        REQ_FIND: begin
          if (hit >= 0) begin
            r.slot = SLOT_W'(hit);
            if (tbl_status[hit] != ST_COMPLETE) begin
              r.rc = RC_NOT_READY;
            end else if (tbl_refs[hit] >= REF_MAX) begin
              tbl_refs[hit] = REF_MAX;
              r.rc          = RC_REF_ERROR;
            end else begin
              tbl_refs[hit]++;
              r.rc = RC_OK;
            end
          end
        end
        REQ_RELEASE: begin
          if (hit >= 0) begin
            r.slot = SLOT_W'(hit);
            if (tbl_refs[hit] == 0) begin
              r.rc = RC_REF_ERROR;
            end else begin
              tbl_refs[hit]--;
              r.rc = RC_OK;
            end
          end
        end
        REQ_INVAL: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tbl_file[i] == fid) begin
              if (tbl_refs[i] != 0) r.inuse = 1'b1;
              tbl_status[i] = ST_INVALID;
              r.rc          = RC_OK;
            end
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic add_row(input logic [REQ_W-1:0] req, input logic [FILE_W-1:0] fid,
                         input logic [BLOCK_W-1:0] blk, input logic typed,
                         input rc_e rc = RC_OK, input int unsigned slot = 0,
                         input logic dup = 1'b0, input logic inuse = 1'b0);
    dir_row_t row;
    row.req        = req;
    row.fid        = fid;
    row.blk        = blk;
    row.typed      = typed;
    row.want.rc    = rc;
    row.want.slot  = SLOT_W'(slot);
    row.want.dup   = dup;
    row.want.inuse = inuse;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Offer one request, hold it until the transfer, then queue its response
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [FILE_W-1:0] fid,
                          input logic [BLOCK_W-1:0] blk, input logic typed = 1'b0,
                          input table_rsp_t want = '0);
    table_rsp_t model_rsp;
    req_if.valid     <= 1'b1;
    req_if.req_type  <= req;
    req_if.file_id   <= fid;
    req_if.block_idx <= blk;
    do @(posedge clk_i); while (!req_if.ready);
    model_rsp = table_update(req, fid, blk);
    pending_rsp_q.insert(pending_rsp_q.size(), typed ? want : model_rsp);
    if (!steady_tail && $urandom_range(0, 99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Response side: check each transfer, then pick the next ready
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: unexpected response rc=%0d slot=%0d", $time,
                   rsp_if.result_code, rsp_if.slot);
          n_errors++;
        end else begin
          table_rsp_t want;
          want = pending_rsp_q.pop_front();
          if (rsp_if.result_code !== want.rc) begin
            $display("%0t: result_code expected %0d, actual %0d", $time, want.rc,
                     rsp_if.result_code);
            n_errors++;
          end
          if (rsp_if.slot !== want.slot) begin
            $display("%0t: slot expected %0d, actual %0d", $time, want.slot, rsp_if.slot);
            n_errors++;
          end
          if (rsp_if.duplicate_key !== want.dup) begin
            $display("%0t: duplicate_key expected %0b, actual %0b", $time, want.dup,
                     rsp_if.duplicate_key);
            n_errors++;
          end
          if (rsp_if.in_use_hit !== want.inuse) begin
            $display("%0t: in_use_hit expected %0b, actual %0b", $time, want.inuse,
                     rsp_if.in_use_hit);
            n_errors++;
          end
        end
      end
      rcv_cycle++;
      if (rcv_cycle % 200 == 0) rcv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      if (hold_rsp_req) begin
        hold_rsp_req = 1'b0;
        hold_cnt     = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_if.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        rsp_if.ready <= 1'b0;
      end else if (!steady_tail && $urandom_range(0, 99) < rcv_idle_pct) begin
        stall_cnt = $urandom_range(1, 9) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Request side: reset, directed table, saturation and fill, then random traffic
  initial begin
    key_t        k;
    int unsigned sel;
    logic [REQ_W-1:0] op;
    n_errors     = 0;
    snd_idle_pct = 30;
    rcv_idle_pct = 30;
    rcv_cycle    = 0;
    stall_cnt    = 0;
    hold_cnt     = 0;
    hold_rsp_req = 1'b0;
    steady_tail  = 1'b0;
    ring_ptr     = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_file[i]   = '0;
      tbl_block[i]  = '0;
      tbl_status[i] = ST_INVALID;
      tbl_refs[i]   = 0;
    end
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.req_type  <= REQ_ALLOC;
    req_if.file_id   <= '0;
    req_if.block_idx <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; typed responses follow from the reset state
    add_row(REQ_FIND,     16'h0001, 32'h0,         1'b1, RC_NOT_FOUND, 0);
    add_row(REQ_ALLOC,    16'hFFFF, 32'hFFFF_FFFF, 1'b1, RC_OK, 0, 1'b0);
    add_row(REQ_ALLOC,    16'hFFFF, 32'hFFFF_FFFF, 1'b1, RC_OK, 1, 1'b1);
    add_row(REQ_FIND,     16'hFFFF, 32'hFFFF_FFFF, 1'b1, RC_NOT_READY, 0);
    add_row(REQ_COMPLETE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, RC_OK, 0);
    add_row(REQ_FIND,     16'hFFFF, 32'hFFFF_FFFF, 1'b1, RC_OK, 0);
    add_row(REQ_RELEASE,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, RC_OK, 0);
    add_row(REQ_RELEASE,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, RC_REF_ERROR, 0);
    add_row(REQ_ALLOC,    16'h0001, 32'h0,         1'b1, RC_OK, 2);
    add_row(REQ_COMPLETE, 16'h0001, 32'h0,         1'b0);
    add_row(REQ_FIND,     16'h0001, 32'h0,         1'b0);
    add_row(REQ_FIND,     16'h0001, 32'h0,         1'b0);
    add_row(REQ_INVAL,    16'hFFFF, 32'h1234_5678, 1'b1, RC_OK, 0, 1'b0, 1'b0);
    add_row(REQ_INVAL,    16'h0001, 32'h0,         1'b1, RC_OK, 0, 1'b0, 1'b1);
    add_row(REQ_INVAL,    16'h0002, 32'h0,         1'b1, RC_NOT_FOUND, 0);
    add_row(REQ_FIND,     16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    add_row(REQ_COMPLETE, 16'h0001, 32'h0,         1'b0);
    add_row(REQ_ALLOC,    16'h0000, 32'h0,         1'b1, RC_NOT_FOUND, 0);
    add_row(REQ_FIND,     16'h0000, 32'h0,         1'b1, RC_NOT_FOUND, 0);
    add_row(REQ_RSVD_A,   16'h0001, 32'h0,         1'b1, RC_NOT_FOUND, 0);
    add_row(REQ_RSVD_B,   16'h0001, 32'h0,         1'b1, RC_NOT_FOUND, 0);
    add_row(REQ_RSVD_C,   16'h0001, 32'h0,         1'b1, RC_NOT_FOUND, 0);
    add_row(REQ_ALLOC,    16'h5A5A, 32'hA5A5_0000, 1'b0);
    add_row(REQ_RELEASE,  16'h0001, 32'h0,         1'b0);
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req, dir_rows[i].fid, dir_rows[i].blk, dir_rows[i].typed,
               dir_rows[i].want);
    end

    // Drive one count into saturation, then step back off it
    send_req(REQ_ALLOC, 16'h8001, 32'h1);
    send_req(REQ_COMPLETE, 16'h8001, 32'h1);
    repeat (REF_MAX + 1) send_req(REQ_FIND, 16'h8001, 32'h1);
    send_req(REQ_RELEASE, 16'h8001, 32'h1);

    // Fill every free slot with pending entries until allocate runs out, then free them
    for (int n = 0; n <= NUM_SLOTS; n++) send_req(REQ_ALLOC, 16'h0100, 32'(n));
    send_req(REQ_INVAL, 16'h0100, 32'h0);

    // Random traffic, mostly on a pool of recently allocated keys
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) snd_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      if (n == N_RANDOM - 150) steady_tail = 1'b1;
      if (n == 300) hold_rsp_req = 1'b1;
      if (n == 600) begin
        // pause until every outstanding response has come back
        req_if.valid <= 1'b0;
        wait (pending_rsp_q.size() == 0);
        @(posedge clk_i);
      end
      if (live_keys.size() > 0 && $urandom_range(0, 4) != 0) begin
        k = live_keys[$urandom_range(0, live_keys.size() - 1)];
      end else begin
        k.fid = ($urandom_range(0, 3) == 0) ? FILE_W'($urandom_range(1, 16'hFFFF))
                                            : FILE_W'($urandom_range(1, 6));
        k.blk = ($urandom_range(0, 1) == 0) ? $urandom : BLOCK_W'($urandom_range(0, 15));
      end
      sel = $urandom_range(0, 99);
      if (sel < 26) op = REQ_ALLOC;
      else if (sel < 46) op = REQ_COMPLETE;
      else if (sel < 70) op = REQ_FIND;
      else if (sel < 88) op = REQ_RELEASE;
      else if (sel < 93) op = REQ_INVAL;
      else if (sel < 97) begin
        op    = REQ_W'($urandom_range(REQ_ALLOC, REQ_INVAL));
        k.fid = '0;
      end else op = REQ_W'($urandom_range(REQ_RSVD_A, REQ_RSVD_C));
      if (op == REQ_ALLOC && k.fid != '0) begin
        live_keys.insert(live_keys.size(), k);
        if (live_keys.size() > 48) void'(live_keys.pop_front());
      end
      send_req(op, k.fid, k.blk);
    end
    req_if.valid <= 1'b0;

    // Drain, allow for the block's latency, then report
    wait (pending_rsp_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
